### hw/rtl/lcp_pkg.sv
// Shared types, constants and the nucleotide code table for the LCP core parser.
// No dependencies; every other file imports this package.
package lcp_pkg;

  localparam int unsigned LCP_POSITION_BITS = 32;
  localparam int unsigned LCP_QUEUE_DEPTH   = 4;
  // A single character can finish at most three cores (a gap, a core and a
  // trailing minimum at sequence end).
  localparam int unsigned LCP_BURST_MAX     = 3;

  localparam logic [2:0] INVALID_CODE = 3'd4;

  typedef enum logic [1:0] {
    KIND_GAP = 2'd0,
    KIND_RUN = 2'd1,
    KIND_MIN = 2'd2,
    KIND_MAX = 2'd3
  } core_kind_e;

  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       end_of_sequence;
  } sym_item_t;

  typedef struct packed {
    logic [31:0] core_start;
    logic [31:0] core_end;
    logic [2:0]  first_symbol;
    logic [2:0]  penultimate_symbol;
    logic [2:0]  final_symbol;
    core_kind_e  core_kind;
    logic        last_of_burst;
  } core_item_t;

  function automatic logic [2:0] code_of(input logic [7:0] b);
    logic [2:0] code;
    unique case (b) inside
      8'h00, 8'h41, 8'h61:        code = 3'd0;  // A a
      8'h01, 8'h43, 8'h63:        code = 3'd1;  // C c
      8'h02, 8'h47, 8'h67:        code = 3'd2;  // G g
      8'h03, 8'h54, 8'h74,
      8'h55, 8'h75:               code = 3'd3;  // T t U u
      default:                    code = INVALID_CODE;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/lcp_if.sv
// Channel interfaces of the LCP core parser: symbol input, core output and
// the offset register write port. Depends on lcp_pkg.
interface lcp_sym_if import lcp_pkg::*; ();
  logic      valid;
  logic      ready;
  sym_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lcp_core_if import lcp_pkg::*; ();
  logic       valid;
  logic       ready;
  core_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lcp_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] wdata;

  modport source (output valid, output wdata, input ready);
  modport sink (input valid, input wdata, output ready);
endinterface

### hw/rtl/dna_lcp_core_parser.sv
// Level-one LCP core parser. Accepts one character per cycle while the burst
// queue is not full. A core passes through the burst queue and the output
// register to the channel, three characters behind the character it is decided on.
// Cores go out one per cycle while the channel is ready, so a character finishing
// up to three cores sends them in turn; the burst queue absorbs the difference.
// Reset (async, active low) clears the window, history, queue and offset.
module dna_lcp_core_parser import lcp_pkg::*; #(
  parameter int unsigned POSITION_BITS = LCP_POSITION_BITS,
  parameter int unsigned QUEUE_DEPTH   = LCP_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcp_sym_if.sink    sym_chan,
  lcp_core_if.source core_chan,
  lcp_cfg_if.sink    cfg_chan
);

  typedef struct packed {
    logic [POSITION_BITS-1:0] start_pos;
    logic [POSITION_BITS-1:0] end_pos;
    logic [2:0]               first_sym;
    logic [2:0]               pen_sym;
    logic [2:0]               last_sym;
    core_kind_e               kind;
  } core_rec_t;

  typedef struct packed {
    logic [1:0]                          count;
    core_rec_t [LCP_BURST_MAX-1:0]       cores;
  } burst_t;

  logic   push, full, q_valid, q_pop;
  burst_t push_data, q_data;

  lcp_front #(
    .POSITION_BITS (POSITION_BITS),
    .core_rec_t    (core_rec_t),
    .burst_t       (burst_t)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sym_chan (sym_chan),
    .push_o   (push),
    .burst_o  (push_data),
    .full_i   (full)
  );

  lcp_queue #(
    .entry_t (burst_t),
    .DEPTH   (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  lcp_back #(
    .POSITION_BITS (POSITION_BITS),
    .burst_t       (burst_t)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .core_chan (core_chan),
    .cfg_chan  (cfg_chan)
  );

endmodule

### hw/rtl/lcp_queue.sv
// Small FIFO of core bursts between the parser front and the output back.
// Depends on lcp_pkg for the default depth.
module lcp_queue import lcp_pkg::*; #(
  parameter type         entry_t = logic,
  parameter int unsigned DEPTH   = LCP_QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t data_o,
  input  logic   pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t         mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("burst pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("burst popped from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

### hw/rtl/lcp_front.sv
// Parser front: maps characters, keeps the scan window and run/core history,
// and pushes one burst per character that finishes any core. Depends on lcp_pkg, lcp_if.
module lcp_front import lcp_pkg::*; #(
  parameter int unsigned POSITION_BITS = LCP_POSITION_BITS,
  parameter type         core_rec_t    = logic,
  parameter type         burst_t       = logic
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  lcp_sym_if.sink sym_chan,
  output logic    push_o,
  output burst_t  burst_o,
  input  logic    full_i
);

  localparam int unsigned PB = POSITION_BITS;
  typedef logic [PB-1:0] pos_t;
  localparam pos_t POS_MAX = {PB{1'b1}};

  typedef struct packed {
    logic      set_inv;
    logic      gap_v;
    logic      core_v;
    logic      open_run;
    logic      run_gap;
    core_rec_t gap;
    core_rec_t core;
  } decision_t;

  function automatic pos_t sat_add(input pos_t a, input pos_t b);
    logic [PB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PB] ? POS_MAX : s[PB-1:0];
  endfunction

  function automatic logic gap_wanted(input pos_t i, input logic have_prev,
                                      input pos_t prev_end, input logic have_inv,
                                      input pos_t last_inv);
    logic clean;
    clean = !have_inv || (prev_end != '0 && last_inv < prev_end - pos_t'(1));
    return have_prev && (prev_end < i) && clean;
  endfunction

  // Classify position i from its neighbors am1 .. a3.
  function automatic decision_t decide(input pos_t i, input logic [2:0] am1,
                                       input logic [2:0] a0, input logic [2:0] a1,
                                       input logic [2:0] a2, input logic [2:0] a3,
                                       input logic has3, input logic at_zero,
                                       input logic have_prev, input pos_t prev_end,
                                       input logic [2:0] prev_last,
                                       input logic have_inv, input pos_t last_inv);
    decision_t d;
    logic      gw;
    d  = '0;
    gw = gap_wanted(i, have_prev, prev_end, have_inv, last_inv);
    d.gap.start_pos  = prev_end - pos_t'(1);
    d.gap.end_pos    = sat_add(i, pos_t'(1));
    d.gap.first_sym  = prev_last;
    d.gap.pen_sym    = am1;
    d.gap.last_sym   = a0;
    d.gap.kind       = KIND_GAP;
    d.core.start_pos = i;
    d.core.first_sym = a0;
    if (a0 == INVALID_CODE) begin
      d.set_inv = 1'b1;
    end else if (a0 != a1) begin
      if (a1 == a2) begin
        if (has3 && a3 != a2) begin
          d.core_v        = 1'b1;
          d.core.end_pos  = sat_add(i, pos_t'(4));
          d.core.pen_sym  = a2;
          d.core.last_sym = a3;
          d.core.kind     = KIND_RUN;
        end else if (has3) begin
          d.open_run = 1'b1;
        end
      end else if (a0 > a1 && a1 < a2) begin
        d.core_v        = 1'b1;
        d.core.end_pos  = sat_add(i, pos_t'(3));
        d.core.pen_sym  = a1;
        d.core.last_sym = a2;
        d.core.kind     = KIND_MIN;
      end else if (!at_zero && has3 && a0 < a1 && a1 > a2 && am1 <= a0 && a2 >= a3) begin
        d.core_v        = 1'b1;
        d.core.end_pos  = sat_add(i, pos_t'(3));
        d.core.pen_sym  = a1;
        d.core.last_sym = a2;
        d.core.kind     = KIND_MAX;
      end
    end
    d.gap_v   = d.core_v && gw;
    d.run_gap = gw;
    return d;
  endfunction

  // window: last four codes, index 0 oldest
  logic [3:0][2:0] win_q, win_d;
  pos_t            pos_q, pos_d;
  logic [2:0]      pend_q, pend_d;
  logic            have_prev_q, have_prev_d;
  pos_t            prev_end_q, prev_end_d;
  logic [2:0]      prev_last_q, prev_last_d;
  logic            have_inv_q, have_inv_d;
  pos_t            last_inv_q, last_inv_d;
  logic            run_open_q, run_open_d;
  logic            run_gap_q, run_gap_d;
  pos_t            run_start_q, run_start_d;
  pos_t            run_len_q, run_len_d;
  logic [2:0]      run_first_q, run_first_d;
  logic [2:0]      run_before_q, run_before_d;
  logic [2:0]      run_sym_q, run_sym_d;

  logic       fire, eos;
  logic [2:0] c;
  logic       run_close, run_cont;
  pos_t       run_end;
  logic       b_en, c_en;
  pos_t       i_b, i_c;
  decision_t  dec_b, dec_c;
  logic       inv_b;
  pos_t       last_inv_b;
  core_rec_t  cand [6];
  logic [5:0] cand_v;
  logic [1:0] cnt;

  assign sym_chan.ready = !full_i;
  assign fire = sym_chan.valid && sym_chan.ready;
  assign c    = code_of(sym_chan.payload.symbol_byte);
  assign eos  = sym_chan.payload.end_of_sequence;

  assign run_cont  = run_open_q && (c == run_sym_q);
  assign run_close = run_open_q && (c != run_sym_q);
  assign run_end   = sat_add(sat_add(run_start_q, pos_t'(2)), run_len_q);

  assign b_en = (pend_q >= 3'd3);
  assign c_en = eos && (pend_q >= 3'd2);
  assign i_b  = pos_q - pos_t'(3);
  assign i_c  = pos_q - pos_t'(2);

  assign dec_b = decide(i_b, win_q[0], win_q[1], win_q[2], win_q[3], c, 1'b1,
                        pend_q == 3'd3, have_prev_q, prev_end_q, prev_last_q,
                        have_inv_q, last_inv_q);

  assign inv_b      = have_inv_q || (b_en && dec_b.set_inv);
  assign last_inv_b = (b_en && dec_b.set_inv) ? i_b : last_inv_q;

  // A core at i_b always ends past i_c, so the end-of-sequence decision
  // never needs a gap after it.
  assign dec_c = decide(i_c, win_q[1], win_q[2], win_q[3], c, INVALID_CODE, 1'b0,
                        pend_q == 3'd2, have_prev_q, prev_end_q, prev_last_q,
                        inv_b, last_inv_b);

  always_comb begin
    cand[0].start_pos = prev_end_q - pos_t'(1);
    cand[0].end_pos   = sat_add(run_start_q, pos_t'(1));
    cand[0].first_sym = prev_last_q;
    cand[0].pen_sym   = run_before_q;
    cand[0].last_sym  = run_first_q;
    cand[0].kind      = KIND_GAP;
    cand[1].start_pos = run_start_q;
    cand[1].end_pos   = run_end;
    cand[1].first_sym = run_first_q;
    cand[1].pen_sym   = run_sym_q;
    cand[1].last_sym  = c;
    cand[1].kind      = KIND_RUN;
    cand[2] = dec_b.gap;
    cand[3] = dec_b.core;
    cand[4] = dec_c.gap;
    cand[5] = dec_c.core;
    cand_v = {c_en && dec_c.core_v,
              c_en && dec_c.gap_v && !(b_en && dec_b.core_v),
              b_en && dec_b.core_v,
              b_en && dec_b.gap_v,
              run_close,
              run_close && run_gap_q};
  end

  // pack the finished cores into the low slots, in scan order
  always_comb begin
    burst_o = '0;
    cnt     = 2'd0;
    for (int k = 0; k < 6; k++) begin
      if (cand_v[k] && cnt != 2'(LCP_BURST_MAX)) begin
        burst_o.cores[cnt] = cand[k];
        cnt = cnt + 2'd1;
      end
    end
    burst_o.count = cnt;
  end

  assign push_o = fire && (cnt != 2'd0);

  always_comb begin
    win_d        = win_q;
    pos_d        = pos_q;
    pend_d       = pend_q;
    have_prev_d  = have_prev_q;
    prev_end_d   = prev_end_q;
    prev_last_d  = prev_last_q;
    have_inv_d   = have_inv_q;
    last_inv_d   = last_inv_q;
    run_open_d   = run_open_q;
    run_gap_d    = run_gap_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    run_first_d  = run_first_q;
    run_before_d = run_before_q;
    run_sym_d    = run_sym_q;
    if (fire && eos) begin
      // drop all history, next character starts a new sequence
      win_d        = {4{INVALID_CODE}};
      pos_d        = '0;
      pend_d       = 3'd0;
      have_prev_d  = 1'b0;
      prev_end_d   = '0;
      prev_last_d  = INVALID_CODE;
      have_inv_d   = 1'b0;
      last_inv_d   = '0;
      run_open_d   = 1'b0;
      run_gap_d    = 1'b0;
      run_start_d  = '0;
      run_len_d    = '0;
      run_first_d  = INVALID_CODE;
      run_before_d = INVALID_CODE;
      run_sym_d    = INVALID_CODE;
    end else if (fire) begin
      win_d  = {c, win_q[3:1]};
      pos_d  = sat_add(pos_q, pos_t'(1));
      pend_d = (pend_q == 3'd4) ? pend_q : pend_q + 3'd1;
      if (run_cont) begin
        run_len_d = sat_add(run_len_q, pos_t'(1));
      end
      if (run_close) begin
        run_open_d  = 1'b0;
        have_prev_d = 1'b1;
        prev_end_d  = run_end;
        prev_last_d = c;
      end
      if (b_en && dec_b.set_inv) begin
        have_inv_d = 1'b1;
        last_inv_d = i_b;
      end
      if (b_en && dec_b.core_v) begin
        have_prev_d = 1'b1;
        prev_end_d  = dec_b.core.end_pos;
        prev_last_d = dec_b.core.last_sym;
      end
      if (b_en && dec_b.open_run) begin
        run_open_d   = 1'b1;
        run_gap_d    = dec_b.run_gap;
        run_start_d  = i_b;
        run_first_d  = win_q[1];
        run_before_d = win_q[0];
        run_sym_d    = win_q[2];
        run_len_d    = pos_t'(3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= {4{INVALID_CODE}};
      pos_q        <= '0;
      pend_q       <= 3'd0;
      have_prev_q  <= 1'b0;
      prev_end_q   <= '0;
      prev_last_q  <= INVALID_CODE;
      have_inv_q   <= 1'b0;
      last_inv_q   <= '0;
      run_open_q   <= 1'b0;
      run_gap_q    <= 1'b0;
      run_start_q  <= '0;
      run_len_q    <= '0;
      run_first_q  <= INVALID_CODE;
      run_before_q <= INVALID_CODE;
      run_sym_q    <= INVALID_CODE;
    end else begin
      win_q        <= win_d;
      pos_q        <= pos_d;
      pend_q       <= pend_d;
      have_prev_q  <= have_prev_d;
      prev_end_q   <= prev_end_d;
      prev_last_q  <= prev_last_d;
      have_inv_q   <= have_inv_d;
      last_inv_q   <= last_inv_d;
      run_open_q   <= run_open_d;
      run_gap_q    <= run_gap_d;
      run_start_q  <= run_start_d;
      run_len_q    <= run_len_d;
      run_first_q  <= run_first_d;
      run_before_q <= run_before_d;
      run_sym_q    <= run_sym_d;
    end
  end

  a_run_needs_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> pend_q == 3'd4)
    else $error("run open before the window filled");

  a_invalid_behind_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_inv_q |-> last_inv_q < pos_q)
    else $error("invalid mark ahead of scan position");

  a_prev_end_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_prev_q |-> prev_end_q >= pos_t'(3))
    else $error("previous core end too small, gap start would wrap");

endmodule

### hw/rtl/lcp_back.sv
// Output back end: holds the offset register, walks the head burst one core
// per cycle while the core channel is ready and drives the registered core channel. Depends on lcp_pkg, lcp_if.
module lcp_back import lcp_pkg::*; #(
  parameter int unsigned POSITION_BITS = LCP_POSITION_BITS,
  parameter type         burst_t       = logic
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  burst_t       q_data_i,
  output logic         q_pop_o,
  lcp_core_if.source   core_chan,
  lcp_cfg_if.sink      cfg_chan
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned SW = ((PB > 32) ? PB : 32) + 1;
  localparam logic [SW-1:0] POS_MAX_W = {{(SW - PB){1'b0}}, {PB{1'b1}}};

  function automatic logic [31:0] add_offset(input logic [PB-1:0] a,
                                             input logic [31:0] off);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(off);
    if (s > POS_MAX_W) begin
      s = POS_MAX_W;
    end
    return s[31:0];
  endfunction

  logic [31:0] offset_q;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  core_item_t  out_q;
  logic        load, last;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_chan.valid) begin
      offset_q <= cfg_chan.wdata;
    end
  end

  assign load    = q_valid_i && (!out_valid_q || core_chan.ready);
  assign last    = (idx_q == q_data_i.count - 2'd1);
  assign q_pop_o = load && last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (core_chan.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.core_start         <= add_offset(q_data_i.cores[idx_q].start_pos, offset_q);
      out_q.core_end           <= add_offset(q_data_i.cores[idx_q].end_pos, offset_q);
      out_q.first_symbol       <= q_data_i.cores[idx_q].first_sym;
      out_q.penultimate_symbol <= q_data_i.cores[idx_q].pen_sym;
      out_q.final_symbol       <= q_data_i.cores[idx_q].last_sym;
      out_q.core_kind          <= q_data_i.cores[idx_q].kind;
      out_q.last_of_burst      <= last;
    end
  end

  assign core_chan.valid   = out_valid_q;
  assign core_chan.payload = out_q;

  a_mid_burst_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> q_valid_i)
    else $error("burst left the queue before all its cores went out");

  a_burst_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> q_data_i.count != 2'd0 && idx_q < q_data_i.count)
    else $error("core index outside the head burst");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !core_chan.ready |=> out_valid_q && $stable(out_q))
    else $error("core changed while waiting for transfer");

endmodule

### verif/lcp_core_checker.sv
// Checker for the LCP core parser: predicts the cores of each accepted
// character and compares them with the core channel. Depends on lcp_pkg and lcp_if.
module lcp_core_checker import lcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lcp_sym_if   sym_chan,
  lcp_core_if  core_chan,
  lcp_cfg_if   cfg_chan,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] pos_t;

  localparam pos_t       POS_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam int         MAX_BURST    = 4;
  localparam int         REPORT_LIMIT = 10;
  localparam logic [2:0] NT_A         = 3'd0;
  localparam logic [2:0] NT_C         = 3'd1;
  localparam logic [2:0] NT_G         = 3'd2;
  localparam logic [2:0] NT_T         = 3'd3;

  logic [2:0]  win [5];
  pos_t        seq_pos, prev_stop, inv_pos, run_len, run_start, base_offset;
  logic        have_core, have_inv, run_open, run_gap;
  logic [2:0]  prev_sym, run_first, run_before, run_sym;
  int unsigned seen;
  core_item_t  burst [$];
  core_item_t  cores_due [$];

  function automatic logic [2:0] nt_code(input logic [7:0] b);
    case (b)
      8'h00, "A", "a":           return NT_A;
      8'h01, "C", "c":           return NT_C;
      8'h02, "G", "g":           return NT_G;
      8'h03, "T", "t", "U", "u": return NT_T;
      default:                   return INVALID_CODE;
    endcase
  endfunction

  function automatic pos_t sat_add(input pos_t a, input pos_t b);
    pos_t s;
    s = a + b;
    if (s < a || s > POS_MAX) return POS_MAX;
    return s;
  endfunction

  function void clear_sequence();
    foreach (win[k]) win[k] = INVALID_CODE;
    seq_pos    = '0;
    prev_stop  = '0;
    have_core  = 1'b0;
    prev_sym   = INVALID_CODE;
    have_inv   = 1'b0;
    inv_pos    = '0;
    run_len    = '0;
    seen       = 0;
    run_open   = 1'b0;
    run_gap    = 1'b0;
    run_start  = '0;
    run_first  = INVALID_CODE;
    run_before = INVALID_CODE;
    run_sym    = INVALID_CODE;
  endfunction

  function void add_core(input pos_t start, input pos_t stop,
                         input logic [2:0] f, pn, l, input core_kind_e kind);
    core_item_t c;
    pos_t       s, e;
    if (burst.size() >= MAX_BURST) return;
    s = sat_add(start, base_offset);
    e = sat_add(stop, base_offset);
    c.core_start         = s[31:0];
    c.core_end           = e[31:0];
    c.first_symbol       = f;
    c.penultimate_symbol = pn;
    c.final_symbol       = l;
    c.core_kind          = kind;
    c.last_of_burst      = 1'b0;
    burst.push_back(c);
  endfunction

  // A gap core bridges the previous core and a new one when no invalid
  // symbol was seen from the previous core's last symbol onward.
  function logic gap_due(input pos_t i);
    if (!have_core || prev_stop >= i) return 1'b0;
    if (!have_inv) return 1'b1;
    return prev_stop > 0 && inv_pos < prev_stop - 1;
  endfunction

  function void add_gap(input pos_t i, input logic [2:0] before_sym, cur_sym);
    add_core(prev_stop - 1, sat_add(i, 1), prev_sym, before_sym, cur_sym, KIND_GAP);
  endfunction

  function void close_core(input pos_t stop, input logic [2:0] sym);
    have_core = 1'b1;
    prev_stop = stop;
    prev_sym  = sym;
  endfunction

  // Decide at position i with neighbors am1 .. a3; a3 exists only if has3.
  function void decide(input pos_t i, input logic [2:0] am1, a0, a1, a2, a3,
                       input logic has3, at_start);
    pos_t stop;
    if (a0 == INVALID_CODE) begin
      have_inv = 1'b1;
      inv_pos  = i;
      return;
    end
    if (a0 == a1) return;
    if (a1 == a2) begin
      if (!has3) return;
      if (a3 != a2) begin
        stop = sat_add(i, 4);
        if (gap_due(i)) add_gap(i, am1, a0);
        add_core(i, stop, a0, a2, a3, KIND_RUN);
        close_core(stop, a3);
      end else begin
        // open a run; its core comes out when a differing symbol arrives
        run_open   = 1'b1;
        run_gap    = gap_due(i);
        run_start  = i;
        run_first  = a0;
        run_before = am1;
        run_sym    = a1;
        run_len    = 3;
      end
      return;
    end
    if (a0 > a1 && a1 < a2) begin
      stop = sat_add(i, 3);
      if (gap_due(i)) add_gap(i, am1, a0);
      add_core(i, stop, a0, a1, a2, KIND_MIN);
      close_core(stop, a2);
      return;
    end
    if (at_start) return;
    if (has3 && a0 < a1 && a1 > a2 && am1 <= a0 && a2 >= a3) begin
      stop = sat_add(i, 3);
      if (gap_due(i)) add_gap(i, am1, a0);
      add_core(i, stop, a0, a1, a2, KIND_MAX);
      close_core(stop, a2);
    end
  endfunction

  function void predict_cores(input logic [7:0] b, input logic eos);
    logic [2:0]  c;
    pos_t        p, stop;
    int unsigned prior;
    core_item_t  tail;
    c     = nt_code(b);
    p     = seq_pos;
    prior = seen;
    burst.delete();
    for (int k = 0; k < 4; k++) win[k] = win[k + 1];
    win[4] = c;
    if (run_open) begin
      if (c == run_sym) begin
        run_len = sat_add(run_len, 1);
      end else begin
        stop     = sat_add(sat_add(run_start, 2), run_len);
        run_open = 1'b0;
        if (run_gap) add_gap(run_start, run_before, run_first);
        add_core(run_start, stop, run_first, run_sym, c, KIND_RUN);
        close_core(stop, c);
      end
    end
    if (prior >= 3) decide(p - 3, win[0], win[1], win[2], win[3], win[4], 1'b1, prior == 3);
    if (eos) begin
      // flush the last decision, then start over at position zero
      if (prior >= 2) begin
        decide(p - 2, win[1], win[2], win[3], win[4], INVALID_CODE, 1'b0, prior == 2);
      end
      clear_sequence();
    end else begin
      seq_pos = sat_add(p, 1);
      if (seen < 4) seen++;
    end
    if (burst.size() > 0) begin
      tail = burst.pop_back();
      tail.last_of_burst = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[k]) cores_due.push_back(burst[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    core_item_t got, want;
    if (!rst_ni) begin
      base_offset = '0;
      clear_sequence();
      cores_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) base_offset = {32'b0, cfg_chan.wdata};
      if (sym_chan.valid && sym_chan.ready) begin
        predict_cores(sym_chan.payload.symbol_byte, sym_chan.payload.end_of_sequence);
      end
      if (core_chan.valid && core_chan.ready) begin
        got = core_chan.payload;
        if (cores_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT) begin
            $display("%0t: unexpected core start=%h end=%h kind=%0d", $time,
                     got.core_start, got.core_end, got.core_kind);
          end
        end else begin
          want = cores_due.pop_front();
          if (got.core_start !== want.core_start || got.core_end !== want.core_end ||
              got.first_symbol !== want.first_symbol ||
              got.penultimate_symbol !== want.penultimate_symbol ||
              got.final_symbol !== want.final_symbol ||
              got.core_kind !== want.core_kind ||
              got.last_of_burst !== want.last_of_burst) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: core mismatch", $time);
              $display("  expected start=%h end=%h syms=%0d/%0d/%0d kind=%0d last=%b",
                       want.core_start, want.core_end, want.first_symbol,
                       want.penultimate_symbol, want.final_symbol, want.core_kind,
                       want.last_of_burst);
              $display("  actual   start=%h end=%h syms=%0d/%0d/%0d kind=%0d last=%b",
                       got.core_start, got.core_end, got.first_symbol,
                       got.penultimate_symbol, got.final_symbol, got.core_kind,
                       got.last_of_burst);
            end
          end
        end
      end
      pending_o = cores_due.size();
    end
  end

endmodule

### verif/tb_dna_lcp_core_parser.sv
// Top of the LCP core parser testbench: clock, reset, character and offset
// stimulus, output backpressure and the verdict. Depends on lcp_pkg, lcp_if, lcp_core_checker.
module tb_dna_lcp_core_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import lcp_pkg::*;

  localparam int    DRAIN_CYCLES = 8;
  localparam int    PHASE_ITEMS  = 56;
  localparam string BASE_CHARS   = "ACGTUacgtu";

  logic clk_i;
  logic rst_ni;
  int   send_idle = 27;
  int   recv_idle = 63;
  int   fail_count;
  int   pending_cores;
  int   sent;
  int   hold_at;

  lcp_sym_if  sym_chan ();
  lcp_core_if core_chan ();
  lcp_cfg_if  cfg_chan ();

  dna_lcp_core_parser u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sym_chan  (sym_chan),
    .core_chan (core_chan),
    .cfg_chan  (cfg_chan)
  );

  lcp_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sym_chan     (sym_chan),
    .core_chan    (core_chan),
    .cfg_chan     (cfg_chan),
    .fail_count_o (fail_count),
    .pending_o    (pending_cores)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(negedge clk_i) begin
    core_chan.ready = ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic wait_drained(input int extra);
    do @(negedge clk_i); while (pending_cores != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic sym_idle();
    @(negedge clk_i);
    sym_chan.valid = 1'b0;
  endtask

  task automatic send_sym(input logic [7:0] b, input logic eos);
    @(negedge clk_i);
    if (sent == hold_at) begin
      // hold the stream until every pending core has come out
      sym_chan.valid = 1'b0;
      wait_drained(0);
    end
    while ($urandom_range(99) < send_idle) begin
      sym_chan.valid = 1'b0;
      @(negedge clk_i);
    end
    sym_chan.payload.symbol_byte     = b;
    sym_chan.payload.end_of_sequence = eos;
    sym_chan.valid                   = 1'b1;
    do @(posedge clk_i); while (sym_chan.ready !== 1'b1);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_sym(s[k], k == s.len() - 1);
  endtask

  task automatic write_offset(input logic [31:0] value);
    @(negedge clk_i);
    cfg_chan.wdata = value;
    cfg_chan.valid = 1'b1;
    do @(posedge clk_i); while (cfg_chan.ready !== 1'b1);
    @(negedge clk_i);
    cfg_chan.valid = 1'b0;
  endtask

  // Mostly nucleotide text with runs; now and then short, long or pure-noise sequences.
  task automatic send_random_seq();
    int         len, pick;
    logic [7:0] b, prev;
    logic       noisy;
    pick = $urandom_range(99);
    if (pick < 10) len = $urandom_range(1, 2);
    else if (pick < 18) len = $urandom_range(30, 45);
    else len = $urandom_range(3, 16);
    noisy = ($urandom_range(99) < 12);
    prev  = BASE_CHARS[$urandom_range(9)];
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (noisy) b = 8'($urandom_range(255));
      else if (k > 0 && pick < 30) b = prev;
      else if (pick < 38) b = 8'($urandom_range(3));
      else if (pick < 44) b = 8'($urandom_range(255));
      else b = BASE_CHARS[$urandom_range(9)];
      send_sym(b, k == len - 1);
      prev = b;
    end
  endtask

  initial begin
    logic [31:0] offsets [3];
    int          target;
    rst_ni          = 1'b0;
    sym_chan.valid  = 1'b0;
    sym_chan.payload = '0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.wdata  = '0;
    core_chan.ready = 1'b0;
    sent            = 0;
    hold_at         = -1;
    offsets[0]      = $urandom;
    offsets[1]      = 32'hFFFF_FFFF;
    offsets[2]      = 32'hFFFF_FFE0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    write_offset('0);
    // single character with the top byte, then a two-character sequence
    send_sym(8'hFF, 1'b1);
    send_sym(8'h00, 1'b0);
    send_sym(8'h03, 1'b1);
    // minima, a run, a maximum, gaps and an invalid run
    send_text("TaCCCgActGaNNa");
    // run still open at the final character
    send_sym(8'h02, 1'b0);
    send_sym(8'h01, 1'b0);
    send_sym(8'h01, 1'b0);
    send_sym(8'h01, 1'b0);
    send_sym(8'h01, 1'b1);
    // minimum at sequence end with an invalid right neighbor
    send_text("GAN");

    for (int phase = 0; phase < 3; phase++) begin
      sym_idle();
      wait_drained(DRAIN_CYCLES);
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 27 : 0;
      write_offset(offsets[phase]);
      hold_at = (phase < 2) ? sent + $urandom_range(15, 45) : -1;
      target  = sent + PHASE_ITEMS;
      while (sent < target) send_random_seq();
    end

    sym_idle();
    wait_drained(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
